// ===== rtl/axu_pkg.sv =====
package axu_pkg;

	// Width of one raw byte taken from the sensor FIFO.
	localparam int unsigned BYTE_W  = 8;
	// Bytes per FIFO word and the resulting word width.
	localparam int unsigned WORD_BYTES = 3;
	localparam int unsigned WORD_W  = BYTE_W * WORD_BYTES;
	// Signed acceleration count carried in the upper bits of a word.
	localparam int unsigned COUNT_W = 20;
	localparam int unsigned COUNT_LSB = WORD_W - COUNT_W;

	// Marker bits inside a FIFO word.
	localparam int unsigned MARK_END_BIT = 1;
	localparam int unsigned MARK_X_BIT   = 0;

	// Packed output data: X, Y and Z counts padded up to whole bytes.
	localparam int unsigned ODATA_RAW_W = 3 * COUNT_W;
	localparam int unsigned ODATA_W     = ((ODATA_RAW_W + 7) / 8) * 8;

	typedef logic signed [COUNT_W-1:0] count_t;

	// A completed 24-bit word leaving the byte assembler.
	typedef struct packed {
		logic              valid;
		logic [WORD_W-1:0] data;
	} word_t;

	// One result leaving the axis tracker.
	typedef struct packed {
		logic   valid;
		count_t x;
		count_t y;
		count_t z;
		logic   fifo_end;
	} result_t;

endpackage

// ===== rtl/axu_word_asm.sv =====
module axu_word_asm
	import axu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] fifo_byte,
	output word_t             word
);

	localparam logic [1:0] PH_HIGH = 2'd0;
	localparam logic [1:0] PH_MID  = 2'd1;
	localparam logic [1:0] PH_LOW  = 2'd2;

	logic [1:0]          byte_phase_q;
	logic [1:0]          byte_phase_d;
	logic [2*BYTE_W-1:0] word_upper_q;
	logic [2*BYTE_W-1:0] word_upper_d;

	always_comb begin
		byte_phase_d = byte_phase_q;
		word_upper_d = word_upper_q;
		word.valid   = 1'b0;
		word.data    = {word_upper_q, fifo_byte};
		unique case (byte_phase_q)
			PH_HIGH: begin
				word_upper_d = {fifo_byte, {BYTE_W{1'b0}}};
				byte_phase_d = PH_MID;
			end
			PH_MID: begin
				word_upper_d = {word_upper_q[2*BYTE_W-1:BYTE_W], fifo_byte};
				byte_phase_d = PH_LOW;
			end
			// The low byte; the unused fourth code behaves the same way.
			default: begin
				word.valid   = step;
				byte_phase_d = PH_HIGH;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_phase_q <= PH_HIGH;
			word_upper_q <= '0;
		end else if (step) begin
			byte_phase_q <= byte_phase_d;
			word_upper_q <= word_upper_d;
		end
	end

endmodule

// ===== rtl/axu_axis_track.sv =====
module axu_axis_track
	import axu_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  word_t   word,
	output result_t result
);

	localparam logic [1:0] AX_WAIT_X = 2'd0;
	localparam logic [1:0] AX_WAIT_Y = 2'd1;
	localparam logic [1:0] AX_WAIT_Z = 2'd2;

	logic [1:0] axis_phase_q;
	logic [1:0] axis_phase_d;
	count_t     held_x_q;
	count_t     held_x_d;
	count_t     held_y_q;
	count_t     held_y_d;
	count_t     count;
	logic       is_end;
	logic       is_x;

	assign count  = count_t'(word.data[WORD_W-1:COUNT_LSB]);
	assign is_end = word.data[MARK_END_BIT];
	assign is_x   = word.data[MARK_X_BIT];

	always_comb begin
		axis_phase_d    = axis_phase_q;
		held_x_d        = held_x_q;
		held_y_d        = held_y_q;
		result.valid    = 1'b0;
		result.x        = held_x_q;
		result.y        = held_y_q;
		result.z        = count;
		result.fifo_end = 1'b0;
		if (is_end) begin
			// The end marker wins over the X bit and leaves the triple alone.
			result.valid    = word.valid;
			result.x        = '0;
			result.y        = '0;
			result.z        = '0;
			result.fifo_end = 1'b1;
		end else if (is_x) begin
			held_x_d     = count;
			held_y_d     = '0;
			axis_phase_d = AX_WAIT_Y;
		end else begin
			unique case (axis_phase_q)
				AX_WAIT_X: begin
					// A stray Y or Z word is dropped.
				end
				AX_WAIT_Y: begin
					held_y_d     = count;
					axis_phase_d = AX_WAIT_Z;
				end
				default: begin
					result.valid = word.valid;
					axis_phase_d = AX_WAIT_X;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_phase_q <= AX_WAIT_X;
			held_x_q     <= '0;
			held_y_q     <= '0;
		end else if (word.valid) begin
			axis_phase_q <= axis_phase_d;
			held_x_q     <= held_x_d;
			held_y_q     <= held_y_d;
		end
	end

endmodule

// ===== rtl/accel_fifo_xyz_unpacker_top.sv =====
// Accelerometer FIFO unpacker. Raw bytes read from the sensor FIFO enter on
// the slave stream, one byte per transaction. Every three bytes form a
// 24-bit word, most significant byte first. A word with bit 1 set is the
// end-of-FIFO marker and produces one result with fifo_end set and all
// counts zero. Otherwise bit 0 set marks an X word; the next two sample
// words are taken as Y and Z, and the Z word produces one result with the
// three signed 20-bit counts (word bits 23:4). A Y or Z word that arrives
// while X is awaited is discarded, and a new X word restarts the triple.
// Scaling the counts to physical units is up to the consumer. The block
// accepts one byte per clock cycle: each byte is held in an input register,
// passes combinationally through the byte assembler and axis tracker, and
// any result lands in the output register. Throughput drops only while the
// output register holds a result that the downstream side has not taken.
module accel_fifo_xyz_unpacker_top
	import axu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// Input byte stream.
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [BYTE_W-1:0]  s_tdata,   // [7:0] fifo_byte
	// Result stream.
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [ODATA_W-1:0] m_tdata,   // [19:0] accel_x, [39:20] accel_y,
	                                      // [59:40] accel_z, [63:60] zero
	output logic               m_tuser    // [0] fifo_end
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_free;
	logic              step;
	word_t             word;
	result_t           result;
	result_t           result_s2;

	// The held byte moves on whenever the output register can take a result.
	assign out_free = !result_s2.valid || m_tready;
	assign step     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	axu_word_asm u_word_asm (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.fifo_byte (byte_s1),
		.word      (word)
	);

	axu_axis_track u_axis_track (
		.clk    (clk),
		.arst_n (arst_n),
		.word   (word),
		.result (result)
	);

	// Output register; a completed transaction frees it for the next result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_s2 <= '0;
		end else if (out_free) begin
			result_s2.valid <= result.valid;
			if (result.valid) begin
				result_s2.x        <= result.x;
				result_s2.y        <= result.y;
				result_s2.z        <= result.z;
				result_s2.fifo_end <= result.fifo_end;
			end
		end
	end

	assign m_tvalid = result_s2.valid;
	assign m_tdata  = {{(ODATA_W - ODATA_RAW_W){1'b0}},
	                   result_s2.z, result_s2.y, result_s2.x};
	assign m_tuser  = result_s2.fifo_end;

endmodule

// ===== sim/accel_fifo_xyz_unpacker_top_test.sv =====
module accel_fifo_xyz_unpacker_top_test;
	import axu_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// The run stops here even if the block hangs. The slowest correct run,
	// with both sides idling and long stalls on the result side, stays far
	// below this.
	localparam int CYCLE_LIMIT = 200_000;
	// This margin is used after the last result to catch any stray result
	// that follows it.
	localparam int DRAIN_CYCLES = 10;
	// Least number of input bytes generated in each of the three random phases.
	localparam int PHASE_BYTES = 567;

	// The byte position within a 24-bit FIFO word, most significant byte first.
	typedef enum logic [1:0] {BYTE_HIGH, BYTE_MID, BYTE_LOW} byte_pos_e;
	// Which axis word the sample tracker is waiting for.
	typedef enum logic [1:0] {AWAIT_X, AWAIT_Y, AWAIT_Z} axis_e;
	// The kinds of FIFO word that the stimulus builds.
	typedef enum {WORD_SAMPLE, WORD_X, WORD_END} word_kind_e;

	// One result as the result stream should carry it.
	typedef struct {
		count_t x;
		count_t y;
		count_t z;
		logic   fifo_end;
	} accel_sample_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [BYTE_W-1:0]  s_tdata  = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [ODATA_W-1:0] m_tdata;
	logic               m_tuser;

	// The initial block queues the bytes here, and the driver sends them.
	logic [BYTE_W-1:0] fifo_bytes_to_send[$];
	// The samples and end markers that the block still has to deliver, oldest first.
	accel_sample_t     predicted_samples[$];

	// The state of the predictor. Reset comes only once, at the start, so these simply start at zero.
	byte_pos_e         byte_pos   = BYTE_HIGH;
	logic [15:0]       word_upper = '0;
	axis_e             axis_state = AWAIT_X;
	count_t            held_x     = '0;
	count_t            held_y     = '0;

	// The idle rates in percent. The initial block changes them between phases.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int error_count   = 0;
	int cycle_count   = 0;
	int bytes_queued  = 0;

	accel_fifo_xyz_unpacker_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// The predictor. It takes one accepted byte. When a word completes, it
	// updates the axis tracker and queues any result that the word causes.
	task automatic unpack_byte(input logic [BYTE_W-1:0] fifo_byte);
		logic [WORD_W-1:0] word;
		count_t            count;
		accel_sample_t     sample;
		case (byte_pos)
			BYTE_HIGH: begin
				word_upper = {fifo_byte, 8'h00};
				byte_pos   = BYTE_MID;
			end
			BYTE_MID: begin
				word_upper = {word_upper[15:8], fifo_byte};
				byte_pos   = BYTE_LOW;
			end
			default: begin
				byte_pos = BYTE_HIGH;
				word     = {word_upper, fifo_byte};
				count    = word[WORD_W-1:COUNT_LSB];
				// The end marker takes priority over the X flag. It leaves
				// the partial triple in place.
				if (word[MARK_END_BIT]) begin
					sample = '{x: '0, y: '0, z: '0, fifo_end: 1'b1};
					predicted_samples.push_back(sample);
				end else if (word[MARK_X_BIT]) begin
					// An X word always starts a new triple and drops any partial one.
					held_x     = count;
					held_y     = '0;
					axis_state = AWAIT_Y;
				end else begin
					case (axis_state)
						AWAIT_X: ;  // A Y or Z word arrived before any X word, so it is dropped.
						AWAIT_Y: begin
							held_y     = count;
							axis_state = AWAIT_Z;
						end
						default: begin
							axis_state = AWAIT_X;
							sample = '{x: held_x, y: held_y, z: count, fifo_end: 1'b0};
							predicted_samples.push_back(sample);
						end
					endcase
				end
			end
		endcase
	endtask

	// The driver. It predicts each byte that the block accepts. It refills
	// the bus only when the current transaction has been taken or the bus is
	// empty, so each output gets one assignment per edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready)
				unpack_byte(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (fifo_bytes_to_send.size() != 0 &&
				    $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= fifo_bytes_to_send.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// The result side stalls at random. A new decision is made each cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic check_field(input string field, input logic [COUNT_W-1:0] want,
	                           input logic [COUNT_W-1:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t: %s mismatch, expected 0x%05h, actual 0x%05h",
			         $realtime, field, want, got);
		end
	endtask

	// The monitor. It compares each accepted result with the oldest
	// prediction, one field at a time.
	always @(posedge clk) begin : result_monitor
		accel_sample_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (predicted_samples.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result, expected none, actual tdata 0x%016h tuser %0b",
				         $realtime, m_tdata, m_tuser);
			end else begin
				want = predicted_samples.pop_front();
				check_field("accel_x", want.x, m_tdata[COUNT_W-1:0]);
				check_field("accel_y", want.y, m_tdata[2*COUNT_W-1:COUNT_W]);
				check_field("accel_z", want.z, m_tdata[3*COUNT_W-1:2*COUNT_W]);
				check_field("tdata padding", '0,
				            COUNT_W'(m_tdata[ODATA_W-1:3*COUNT_W]));
				check_field("fifo_end", COUNT_W'(want.fifo_end), COUNT_W'(m_tuser));
			end
		end
	end

	// This watchdog also catches a block that stops delivering results.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("accel_fifo_xyz_unpacker_top_test: errors");
			$finish;
		end
	end

	// Builds one FIFO word. Bits 3:2 carry no meaning, so they are random.
	// An end marker gets a random X flag as well, because the end bit wins.
	function automatic logic [WORD_W-1:0] fifo_word(input word_kind_e kind,
	                                                input logic [COUNT_W-1:0] count);
		logic [1:0] marks;
		case (kind)
			WORD_END: marks = {1'b1, 1'($urandom_range(1))};
			WORD_X:   marks = 2'b01;
			default:  marks = 2'b00;
		endcase
		return {count, 2'($urandom_range(3)), marks};
	endfunction

	// Queues a word as three bytes, most significant byte first.
	task automatic queue_word(input logic [WORD_W-1:0] word);
		fifo_bytes_to_send.push_back(word[23:16]);
		fifo_bytes_to_send.push_back(word[15:8]);
		fifo_bytes_to_send.push_back(word[7:0]);
		bytes_queued += WORD_BYTES;
	endtask

	// Random counts lean toward the extremes of the signed 20-bit range.
	function automatic logic [COUNT_W-1:0] random_count();
		case ($urandom_range(7))
			0:       return 20'h7FFFF;
			1:       return 20'h80000;
			2:       return {20{1'($urandom_range(1))}};
			default: return 20'($urandom);
		endcase
	endfunction

	// Waits until every queued byte is sent and every predicted result has
	// arrived. It then lets the pipeline settle. Any result that follows now
	// is a stray.
	task automatic wait_results_drained();
		do
			@(negedge clk);
		while (fifo_bytes_to_send.size() != 0 || s_tvalid || predicted_samples.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// The directed part: the count extremes, both markers set together,
		// an X word that drops a partial triple, and an end marker inside a
		// triple. A Z word that comes while an X word is awaited is also dropped.
		send_idle_pct = 38;
		recv_idle_pct = 45;
		queue_word(24'h7FFFF1);   // An X word with the largest positive count.
		queue_word(24'h80000C);   // A Y word with the most negative count.
		queue_word(24'hFFFFFD);   // A new X word, which drops the partial triple.
		queue_word(24'h000003);   // Both marker bits are set, so this is an end marker.
		queue_word(24'h000000);   // A Y word with count zero.
		queue_word(24'h800000);   // A Z word, which completes the triple.
		queue_word(24'hFFFFFE);   // An end marker with all other bits set.
		queue_word(24'h7FFFF0);   // A Z word that comes while X is awaited.

		// The sender holds off until every result of the directed part has arrived.
		wait_results_drained();

		// The random part. Each phase sets different idle rates.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 38;
					recv_idle_pct = 45;
				end
				1: begin
					send_idle_pct = 45;
					recv_idle_pct = 38;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			bytes_queued = 0;
			while (bytes_queued < PHASE_BYTES) begin
				case ($urandom_range(9))
					0, 1, 2, 3, 4, 5: begin
						// A well-formed triple. Sometimes an end marker lands inside it.
						queue_word(fifo_word(WORD_X, random_count()));
						queue_word(fifo_word(WORD_SAMPLE, random_count()));
						if ($urandom_range(9) == 0)
							queue_word(fifo_word(WORD_END, random_count()));
						queue_word(fifo_word(WORD_SAMPLE, random_count()));
					end
					6: queue_word(fifo_word(WORD_END, random_count()));
					7: begin
						// A triple that is broken off by a new X word.
						queue_word(fifo_word(WORD_X, random_count()));
						if ($urandom_range(1))
							queue_word(fifo_word(WORD_SAMPLE, random_count()));
						queue_word(fifo_word(WORD_X, random_count()));
						queue_word(fifo_word(WORD_SAMPLE, random_count()));
						queue_word(fifo_word(WORD_SAMPLE, random_count()));
					end
					8: queue_word(fifo_word(WORD_SAMPLE, random_count()));
					default: queue_word(WORD_W'($urandom));
				endcase
			end
			// The next phase starts with new idle rates once this phase's bytes are sent.
			while (fifo_bytes_to_send.size() != 0 || s_tvalid)
				@(negedge clk);
		end

		wait_results_drained();
		if (error_count == 0)
			$display("accel_fifo_xyz_unpacker_top_test: clean");
		else
			$display("accel_fifo_xyz_unpacker_top_test: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/axu_pkg.sv
rtl/axu_word_asm.sv
rtl/axu_axis_track.sv
rtl/accel_fifo_xyz_unpacker_top.sv
sim/accel_fifo_xyz_unpacker_top_test.sv
